// File: sv/assert_macros.svh
// Assertion macros shared by the prime test RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: property failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// File: sv/tdpt_pkg.sv
// Package with shared types and constants of the trial division prime test.
`timescale 1ns / 1ps
package tdpt_pkg;

   // Default width of the tested value.
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // The first divisor tried, and the smallest prime.
   localparam int FIRST_DIVISOR = 2;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE
   } tdpt_state_type;

   // Status that the serial divider reports to the sequencer.
   typedef struct packed {
      logic done;
      logic rem_zero;
   } tdpt_div_status_type;

endpackage

// File: sv/tdpt_serial_div.sv
// Bit-serial restoring divider: one quotient bit per clock cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tdpt_serial_div #(
   parameter int VALUE_WIDTH   = tdpt_pkg::VALUE_WIDTH_DEFAULT,
   parameter int DIVISOR_WIDTH = tdpt_pkg::VALUE_WIDTH_DEFAULT / 2 + 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  logic [VALUE_WIDTH-1:0]            dividend,
   input  logic [DIVISOR_WIDTH-1:0]          divisor,
   output logic [VALUE_WIDTH-1:0]            quotient,
   output tdpt_pkg::tdpt_div_status_type     status
);
   import tdpt_pkg::*;

   localparam int CountWidth = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

   logic [VALUE_WIDTH-1:0]   shift_ff, shift_in;
   logic [DIVISOR_WIDTH-1:0] rem_ff, rem_in;
   logic [DIVISOR_WIDTH-1:0] div_ff, div_in;
   logic [CountWidth-1:0]    count_ff, count_in;
   logic                     running_ff, running_in;
   logic                     done_ff, done_in;
   logic [DIVISOR_WIDTH:0]   trial;
   logic [DIVISOR_WIDTH:0]   diff;
   logic                     q_bit;

   // One restoring step: bring in the next dividend bit and try a subtract.
   always_comb begin
      trial = {rem_ff, shift_ff[VALUE_WIDTH-1]};
      diff  = trial - {1'b0, div_ff};
      q_bit = (trial >= {1'b0, div_ff});
   end

   // Next state of the shift registers and the step counter.
   always_comb begin
      shift_in   = shift_ff;
      rem_in     = rem_ff;
      div_in     = div_ff;
      count_in   = count_ff;
      running_in = running_ff;
      done_in    = 1'b0;
      if (load) begin
         shift_in   = dividend;
         rem_in     = '0;
         div_in     = divisor;
         count_in   = '0;
         running_in = 1'b1;
      end else if (running_ff) begin
         // The dividend leaves at the top while quotient bits enter at the bottom.
         shift_in = {shift_ff[VALUE_WIDTH-2:0], q_bit};
         rem_in   = q_bit ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
         count_in = count_ff + CountWidth'(1);
         if (count_ff == CountWidth'(VALUE_WIDTH - 1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      if (reset) begin
         count_ff   <= '0;
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         count_ff   <= count_in;
         running_ff <= running_in;
         done_ff    <= done_in;
      end
   end

   assign quotient        = shift_ff;
   assign status.done     = done_ff;
   assign status.rem_zero = (rem_ff == '0);

   // The step counter stays below the number of quotient bits.
   `ASSERT_NEVER(a_count_range, clock, reset, count_ff > CountWidth'(VALUE_WIDTH - 1))
   // A division in progress is never reported as finished.
   `ASSERT_NEVER(a_done_idle, clock, reset, done_ff && running_ff)
   // The last step raises done in the following cycle.
   `ASSERT_PROP(a_done_after_last, clock, reset,
      (running_ff && !load && count_ff == CountWidth'(VALUE_WIDTH - 1)) |=> done_ff)

endmodule

// File: sv/trial_division_prime_test_core.sv
// Top level of the trial division prime test.
// Usage: drive req_value and raise start while busy is low; the request is taken
// at that clock edge and busy rises in the next cycle. The magnitude m of the
// signed value is tested; magnitudes 0 and 1 are reported as not prime.
// Divisors d = 2, 3, 4, ... are tried in turn while d <= m / d. Each trial runs
// the bit-serial divider over all VALUE_WIDTH quotient bits; the sequencer then
// judges the result and reloads the divider with the next divisor. The worst
// case, a prime near the top of the range, needs about 46341 trials at 32 bits.
// The divider produces one quotient bit per cycle.
// The result appears on rsp_is_prime with rsp_valid high for exactly one cycle,
// in the cycle in which busy falls; a new request may be given in that same
// cycle. The receiver cannot stall, so the result must be taken when shown.
// Synchronous reset aborts any test in progress, drops busy and rsp_valid, and
// the block is ready for a request in the first cycle after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module trial_division_prime_test_core #(
   parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_valid,
   output logic                          rsp_is_prime
);
   import tdpt_pkg::*;

   // The divisor never exceeds the square root of the magnitude plus one.
   localparam int DivisorWidth = VALUE_WIDTH / 2 + 1;

   tdpt_state_type           state_ff, state_in;
   logic [VALUE_WIDTH-1:0]   mag_ff, mag_in;
   logic [DivisorWidth-1:0]  d_ff, d_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_is_prime_ff, rsp_is_prime_in;
   logic                     div_load;
   logic [VALUE_WIDTH-1:0]   quotient;
   tdpt_div_status_type      div_status;
   logic                     accept;
   logic                     mag_small;
   logic                     past_root;

   assign accept    = start && (state_ff == ST_IDLE);
   assign mag_small = (mag_ff < VALUE_WIDTH'(FIRST_DIVISOR));
   // The trial divisor is above m / d, so no factor is left to find.
   assign past_root = ({{(VALUE_WIDTH - DivisorWidth){1'b0}}, d_ff} > quotient);

   // Magnitude of the request; the most negative value wraps to 2^(W-1).
   always_comb begin
      mag_in = mag_ff;
      if (accept) begin
         mag_in = req_value[VALUE_WIDTH-1] ? ({VALUE_WIDTH{1'b0}} - $unsigned(req_value))
                                           : $unsigned(req_value);
      end
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            state_in = mag_small ? ST_IDLE : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_status.done && (past_root || div_status.rem_zero)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: divider control, divisor update and the result.
   always_comb begin
      div_load        = 1'b0;
      d_in            = d_ff;
      rsp_valid_in    = 1'b0;
      rsp_is_prime_in = 1'b0;
      case (state_ff)
         ST_SETUP: begin
            if (mag_small) begin
               rsp_valid_in = 1'b1;
            end else begin
               d_in     = DivisorWidth'(FIRST_DIVISOR);
               div_load = 1'b1;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               if (past_root) begin
                  rsp_valid_in    = 1'b1;
                  rsp_is_prime_in = 1'b1;
               end else if (div_status.rem_zero) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  d_in     = d_ff + DivisorWidth'(1);
                  div_load = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mag_ff          <= mag_in;
      d_ff            <= d_in;
      rsp_is_prime_ff <= rsp_is_prime_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Shared divider giving m / d and whether m % d is zero for the current trial divisor.
   tdpt_serial_div #(
      .VALUE_WIDTH  (VALUE_WIDTH),
      .DIVISOR_WIDTH(DivisorWidth)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .load    (div_load),
      .dividend(mag_ff),
      .divisor (d_in),
      .quotient(quotient),
      .status  (div_status)
   );

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;

   // A result strobe lasts one cycle only.
   `ASSERT_PROP(a_strobe_single, clock, reset, rsp_valid |=> !rsp_valid)
   // A result is shown only once the test has finished.
   `ASSERT_PROP(a_result_idle, clock, reset, rsp_valid |-> !busy)
   // An accepted request makes the block busy in the next cycle.
   `ASSERT_PROP(a_accept_busy, clock, reset, (start && !busy) |=> busy)
   // The divider finishes only while the sequencer waits for it.
   `ASSERT_PROP(a_done_in_divide, clock, reset, div_status.done |-> (state_ff == ST_DIVIDE))

endmodule
